// ----- rtl/fmpf_pkg.sv -----
// ----------------------------------------------------------------------------
// fmpf_pkg: shared types and constants of the packet filter
// Command and action codes, rule layout, queue item and the rule match test.
// ----------------------------------------------------------------------------
package fmpf_pkg;

  localparam int MAX_RULES_DEF = 64;
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);
  localparam int LOG_W         = 7;

  localparam logic [1:0] CMD_CHECK  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ACT_ALLOW = 2'd0;
  localparam logic [1:0] ACT_LOG   = 2'd2;
  localparam logic [1:0] DIR_BOTH  = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  localparam logic [LOG_W-1:0] LOG_MAX = {LOG_W{1'b1}};
  localparam logic [15:0]      ID_MAX  = 16'hFFFF;
  localparam logic [15:0]      ID_FIRST = 16'd1;

  typedef enum logic [1:0] {
    OP_CHECK,
    OP_ADD,
    OP_REMOVE,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIND,
    S_SHIFT
  } state_t;

  // One rule entry as stored; a packet uses the same layout
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [1:0]  dir;
    logic [1:0]  action;
    logic [15:0] id;
  } rule_t;

  typedef struct packed {
    op_t   op;
    rule_t rule;
  } item_t;

  function automatic logic rule_hit(rule_t r, rule_t p);
    logic ok;
    ok = (r.dir == DIR_BOTH) || (r.dir == p.dir);
    ok = ok && ((r.proto == '0)    || (r.proto == p.proto));
    ok = ok && ((r.src_ip == '0)   || (r.src_ip == p.src_ip));
    ok = ok && ((r.dst_ip == '0)   || (r.dst_ip == p.dst_ip));
    ok = ok && ((r.sport == '0)    || (r.sport == p.sport));
    ok = ok && ((r.dport == '0)    || (r.dport == p.dport));
    return ok;
  endfunction

endpackage

// ----- rtl/fmpf_ram.sv -----
// ----------------------------------------------------------------------------
// fmpf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fmpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fmpf_front.sv -----
// ----------------------------------------------------------------------------
// fmpf_front: input stage of the packet filter
// Accepts input beats, decodes the command and queues the item for the back.
// ----------------------------------------------------------------------------
module fmpf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic [31:0]         src_ip,
  input  logic [31:0]         dst_ip,
  input  logic [15:0]         sport,
  input  logic [15:0]         dport,
  input  logic [7:0]          proto,
  input  logic [1:0]          dir,
  input  logic [1:0]          action,
  input  logic [15:0]         rule_id,
  output logic                q_valid,
  output fmpf_pkg::item_t     q_item,
  input  logic                q_pop
);

  fmpf_pkg::item_t                 slots [fmpf_pkg::Q_DEPTH];
  fmpf_pkg::item_t                 dec;
  logic [fmpf_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [fmpf_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [fmpf_pkg::Q_CNT_W-1:0]    fill;
  logic                            push;

  always_comb begin
    unique case (cmd)
      fmpf_pkg::CMD_CHECK:  dec.op = fmpf_pkg::OP_CHECK;
      fmpf_pkg::CMD_ADD:    dec.op = fmpf_pkg::OP_ADD;
      fmpf_pkg::CMD_REMOVE: dec.op = fmpf_pkg::OP_REMOVE;
      default:              dec.op = fmpf_pkg::OP_NOP;
    endcase
    dec.rule.src_ip = src_ip;
    dec.rule.dst_ip = dst_ip;
    dec.rule.sport  = sport;
    dec.rule.dport  = dport;
    dec.rule.proto  = proto;
    dec.rule.dir    = dir;
    dec.rule.action = action;
    dec.rule.id     = rule_id;
  end

  assign in_ready = (fill != fmpf_pkg::Q_CNT_W'(fmpf_pkg::Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + fmpf_pkg::Q_CNT_W'(push) - fmpf_pkg::Q_CNT_W'(q_pop);
    end
  end

  pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// ----- rtl/fmpf_back.sv -----
// ----------------------------------------------------------------------------
// fmpf_back: rule engine of the packet filter
// Runs add, check and remove against the rule RAM, one rule per cycle.
// ----------------------------------------------------------------------------
module fmpf_back #(
  parameter int MAX_RULES = fmpf_pkg::MAX_RULES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      enable,
  input  logic                      q_valid,
  input  fmpf_pkg::item_t           q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      allow,
  output logic [1:0]                status,
  output logic [15:0]               new_rule_id,
  output logic [fmpf_pkg::LOG_W-1:0] log_hits
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  fmpf_pkg::state_t  state, state_next;
  fmpf_pkg::item_t   cur, cur_next;
  fmpf_pkg::rule_t   rdata, add_rule;

  logic [CNT_W-1:0]  rule_count, rule_count_next;
  logic [15:0]       next_id, next_id_next;
  logic [CNT_W-1:0]  rd_ptr, rd_ptr_next;
  logic              pend, pend_next;
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic [fmpf_pkg::LOG_W-1:0] logs, logs_next;

  logic              out_valid_next;
  logic              allow_next;
  logic [1:0]        status_next;
  logic [15:0]       new_rule_id_next;
  logic [fmpf_pkg::LOG_W-1:0] log_hits_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  fmpf_pkg::rule_t   ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;

  logic issue, at_end, hit, decide, id_hit, full;

  assign q_pop  = (state == fmpf_pkg::S_IDLE) && q_valid && (!out_valid || out_ready);
  assign issue  = (rd_ptr < rule_count);
  assign at_end = !pend && !issue;
  assign hit    = pend && fmpf_pkg::rule_hit(rdata, cur.rule);
  assign decide = hit && (rdata.action != fmpf_pkg::ACT_LOG);
  assign id_hit = pend && (rdata.id == cur.rule.id);
  assign full   = (rule_count == CNT_W'(MAX_RULES));

  always_comb begin
    add_rule    = q_item.rule;
    add_rule.id = next_id;
  end

  fmpf_ram #(
    .WIDTH ($bits(fmpf_pkg::rule_t)),
    .DEPTH (MAX_RULES)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      fmpf_pkg::S_IDLE: begin
        if (q_pop) begin
          if (q_item.op == fmpf_pkg::OP_CHECK && enable) begin
            state_next = fmpf_pkg::S_SCAN;
          end else if (q_item.op == fmpf_pkg::OP_REMOVE) begin
            state_next = fmpf_pkg::S_FIND;
          end
        end
      end
      fmpf_pkg::S_SCAN: begin
        if (decide || at_end) begin
          state_next = fmpf_pkg::S_IDLE;
        end
      end
      fmpf_pkg::S_FIND: begin
        if (id_hit) begin
          state_next = fmpf_pkg::S_SHIFT;
        end else if (at_end) begin
          state_next = fmpf_pkg::S_IDLE;
        end
      end
      fmpf_pkg::S_SHIFT: begin
        if (at_end) begin
          state_next = fmpf_pkg::S_IDLE;
        end
      end
      default: state_next = fmpf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cur_next         = cur;
    rule_count_next  = rule_count;
    next_id_next     = next_id;
    rd_ptr_next      = rd_ptr;
    pend_next        = pend;
    pend_idx_next    = pend_idx;
    logs_next        = logs;
    out_valid_next   = out_valid && !out_ready;
    allow_next       = allow;
    status_next      = status;
    new_rule_id_next = new_rule_id;
    log_hits_next    = log_hits;
    ram_we           = 1'b0;
    ram_waddr        = rule_count[IDX_W-1:0];
    ram_wdata        = add_rule;
    ram_raddr        = rd_ptr[IDX_W-1:0];

    // Stream reads through the table while scanning, finding or shifting
    if (state != fmpf_pkg::S_IDLE) begin
      if (issue) begin
        rd_ptr_next   = rd_ptr + CNT_W'(1);
        pend_next     = 1'b1;
        pend_idx_next = rd_ptr[IDX_W-1:0];
      end else begin
        pend_next = 1'b0;
      end
    end

    unique case (state)
      fmpf_pkg::S_IDLE: begin
        if (q_pop) begin
          cur_next    = q_item;
          rd_ptr_next = '0;
          pend_next   = 1'b0;
          logs_next   = '0;
          allow_next       = 1'b0;
          status_next      = fmpf_pkg::STAT_OK;
          new_rule_id_next = '0;
          log_hits_next    = '0;
          unique case (q_item.op)
            fmpf_pkg::OP_CHECK: begin
              if (!enable) begin
                out_valid_next = 1'b1;
                allow_next     = 1'b1;
              end
            end
            fmpf_pkg::OP_ADD: begin
              out_valid_next = 1'b1;
              if (full) begin
                status_next = fmpf_pkg::STAT_FULL;
              end else begin
                ram_we           = 1'b1;
                new_rule_id_next = next_id;
                rule_count_next  = rule_count + CNT_W'(1);
                next_id_next     = (next_id == fmpf_pkg::ID_MAX) ? fmpf_pkg::ID_FIRST
                                                                 : next_id + 16'd1;
              end
            end
            fmpf_pkg::OP_REMOVE: ;
            default: out_valid_next = 1'b1;
          endcase
        end
      end
      fmpf_pkg::S_SCAN: begin
        if (decide) begin
          out_valid_next = 1'b1;
          allow_next     = (rdata.action == fmpf_pkg::ACT_ALLOW);
          log_hits_next  = logs;
        end else if (hit) begin
          if (logs != fmpf_pkg::LOG_MAX) begin
            logs_next = logs + fmpf_pkg::LOG_W'(1);
          end
        end else if (at_end) begin
          out_valid_next = 1'b1;
          allow_next     = 1'b1;
          log_hits_next  = logs;
        end
      end
      fmpf_pkg::S_FIND: begin
        if (id_hit) begin
          // restart reads just past the matching entry
          rd_ptr_next = CNT_W'(pend_idx) + CNT_W'(1);
          pend_next   = 1'b0;
        end else if (at_end) begin
          out_valid_next = 1'b1;
          status_next    = fmpf_pkg::STAT_NOT_FOUND;
        end
      end
      fmpf_pkg::S_SHIFT: begin
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx - IDX_W'(1);
          ram_wdata = rdata;
        end
        if (at_end) begin
          rule_count_next = rule_count - CNT_W'(1);
          out_valid_next  = 1'b1;
          status_next     = fmpf_pkg::STAT_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fmpf_pkg::S_IDLE;
      rule_count <= '0;
      next_id    <= fmpf_pkg::ID_FIRST;
      rd_ptr     <= '0;
      pend       <= 1'b0;
      logs       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rule_count <= rule_count_next;
      next_id    <= next_id_next;
      rd_ptr     <= rd_ptr_next;
      pend       <= pend_next;
      logs       <= logs_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur         <= cur_next;
    pend_idx    <= pend_idx_next;
    allow       <= allow_next;
    status      <= status_next;
    new_rule_id <= new_rule_id_next;
    log_hits    <= log_hits_next;
  end

  count_in_range: assert property (@(posedge clk) disable iff (rst)
    rule_count <= CNT_W'(MAX_RULES))
    else $error("rule count beyond table size");

  count_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    (rule_count == $past(rule_count)) ||
    (rule_count == $past(rule_count) + CNT_W'(1)) ||
    (rule_count == $past(rule_count) - CNT_W'(1)))
    else $error("rule count jumped");

  id_never_zero: assert property (@(posedge clk) disable iff (rst)
    next_id != '0)
    else $error("rule id counter reached zero");

  shift_needs_rules: assert property (@(posedge clk) disable iff (rst)
    (state == fmpf_pkg::S_SHIFT) |-> (rule_count != '0))
    else $error("shifting an empty table");

endmodule

// ----- rtl/first_match_packet_filter_core.sv -----
// ----------------------------------------------------------------------------
// first_match_packet_filter_core: ordered first-match packet filter
// Rule table with add, remove and check commands over valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command beat: check a packet,
//   add a rule or remove a rule by id. Output channel (out_valid/out_ready)
//   returns exactly one result beat per command, in order.
//   Config channel (cfg_valid/cfg_ready) writes filter_enable; write it only
//   while no command is outstanding. cfg_ready is always high.
//   A two-entry queue sits between input decode and the rule engine, so input
//   beats keep being taken while a result waits on a stalled receiver.
//   An idle engine with its result channel free takes a beat off the queue the cycle after it is accepted.
//   Add, unused commands and checks while disabled are answered straight
//   from the idle state. A check reads the rules in order until the first
//   matching rule that is not a log rule decides, else allows at the end.
//   A remove searches for the id, reports not found if it is absent, else
//   moves every later rule one slot up.
//   The single-port-read rule RAM sets the pace: one rule per cycle.
//   Reset empties the table, sets the next id to 1 and disables filtering.
//   When out_ready is low the result holds and the engine waits.
// ----------------------------------------------------------------------------
module first_match_packet_filter_core #(
  parameter int MAX_RULES = fmpf_pkg::MAX_RULES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       filter_enable,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 cmd,
  input  logic [31:0]                src_ip,
  input  logic [31:0]                dst_ip,
  input  logic [15:0]                sport,
  input  logic [15:0]                dport,
  input  logic [7:0]                 proto,
  input  logic [1:0]                 dir,
  input  logic [1:0]                 action,
  input  logic [15:0]                rule_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       allow,
  output logic [1:0]                 status,
  output logic [15:0]                new_rule_id,
  output logic [fmpf_pkg::LOG_W-1:0] log_hits
);

  logic            enable;
  logic            q_valid;
  logic            q_pop;
  fmpf_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enable <= filter_enable;
    end
  end

  fmpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .src_ip   (src_ip),
    .dst_ip   (dst_ip),
    .sport    (sport),
    .dport    (dport),
    .proto    (proto),
    .dir      (dir),
    .action   (action),
    .rule_id  (rule_id),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  fmpf_back #(
    .MAX_RULES (MAX_RULES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .enable      (enable),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .allow       (allow),
    .status      (status),
    .new_rule_id (new_rule_id),
    .log_hits    (log_hits)
  );

endmodule

// ----- tb/fmpf_verdict_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpf_verdict_checker: result checker for the first-match packet filter
// Watches the config, command and result channels. Keeps its own rule list,
// id counter and enable bit, computes the result of each accepted command
// and compares every result beat with the oldest owed one.
// ----------------------------------------------------------------------------
module fmpf_verdict_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       filter_enable,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 cmd,
  input  logic [31:0]                src_ip,
  input  logic [31:0]                dst_ip,
  input  logic [15:0]                sport,
  input  logic [15:0]                dport,
  input  logic [7:0]                 proto,
  input  logic [1:0]                 dir,
  input  logic [1:0]                 action,
  input  logic [15:0]                rule_id,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       allow,
  input  logic [1:0]                 status,
  input  logic [15:0]                new_rule_id,
  input  logic [fmpf_pkg::LOG_W-1:0] log_hits,
  output int                         fail_count,
  output int                         results_owed,
  output logic [15:0]                next_id_seen
);

  typedef struct packed {
    logic                       allow;
    logic [1:0]                 status;
    logic [15:0]                new_id;
    logic [fmpf_pkg::LOG_W-1:0] logs;
  } verdict_t;

  fmpf_pkg::rule_t rule_list [fmpf_pkg::MAX_RULES_DEF];
  int              rule_total;
  logic [15:0]     id_next;
  logic            enabled;
  verdict_t        owed_verdicts [$];
  fmpf_pkg::rule_t in_beat;

  assign in_beat = {src_ip, dst_ip, sport, dport, proto, dir, action, rule_id};

  function automatic bit field_ok(logic [31:0] rule_val, logic [31:0] pkt_val);
    return (rule_val == '0) || (rule_val == pkt_val);
  endfunction

  function automatic bit rule_matches(fmpf_pkg::rule_t r, fmpf_pkg::rule_t p);
    if (r.dir != fmpf_pkg::DIR_BOTH && r.dir != p.dir) return 1'b0;
    return field_ok(32'(r.proto), 32'(p.proto)) && field_ok(r.src_ip, p.src_ip) &&
           field_ok(r.dst_ip, p.dst_ip) && field_ok(32'(r.sport), 32'(p.sport)) &&
           field_ok(32'(r.dport), 32'(p.dport));
  endfunction

  // Apply one command to the shadow rule list and return its result
  function automatic verdict_t filter_command(logic [1:0] c, fmpf_pkg::rule_t p);
    verdict_t v;
    int       i;
    int       hit;
    bit       decided;
    v = '0;
    case (c)
      fmpf_pkg::CMD_CHECK: begin
        v.allow = 1'b1;
        decided = 1'b0;
        if (enabled) begin
          for (i = 0; i < rule_total && !decided; i++) begin
            if (rule_matches(rule_list[i], p)) begin
              if (rule_list[i].action == fmpf_pkg::ACT_LOG) begin
                if (v.logs != fmpf_pkg::LOG_MAX) v.logs = v.logs + fmpf_pkg::LOG_W'(1);
              end else begin
                v.allow = (rule_list[i].action == fmpf_pkg::ACT_ALLOW);
                decided = 1'b1;
              end
            end
          end
        end
      end
      fmpf_pkg::CMD_ADD: begin
        if (rule_total >= fmpf_pkg::MAX_RULES_DEF) begin
          v.status = fmpf_pkg::STAT_FULL;
        end else begin
          rule_list[rule_total] = p;
          rule_list[rule_total].id = id_next;
          rule_total++;
          v.new_id = id_next;
          id_next = (id_next == fmpf_pkg::ID_MAX) ? fmpf_pkg::ID_FIRST : id_next + 16'd1;
        end
      end
      fmpf_pkg::CMD_REMOVE: begin
        hit = -1;
        for (i = 0; i < rule_total && hit < 0; i++)
          if (rule_list[i].id == p.id) hit = i;
        if (hit < 0) begin
          v.status = fmpf_pkg::STAT_NOT_FOUND;
        end else begin
          // close the gap
          for (i = hit; i < rule_total - 1; i++) rule_list[i] = rule_list[i + 1];
          rule_total--;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst) begin
      rule_total = 0;
      id_next    = fmpf_pkg::ID_FIRST;
      enabled    = 1'b0;
      fail_count = 0;
      owed_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) enabled = filter_enable;
      if (in_valid && in_ready) owed_verdicts.push_back(filter_command(cmd, in_beat));
      if (out_valid && out_ready) begin
        if (owed_verdicts.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          want = owed_verdicts.pop_front();
          compare_field("allow", 16'(want.allow), 16'(allow));
          compare_field("status", 16'(want.status), 16'(status));
          compare_field("new_rule_id", want.new_id, new_rule_id);
          compare_field("log_hits", 16'(want.logs), 16'(log_hits));
        end
      end
    end
    results_owed <= owed_verdicts.size();
    next_id_seen <= id_next;
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the first-match packet filter
// Drives directed rule and packet beats, then random traffic under several
// idle and stall mixes and enable settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0]  CMD_CHECK  = fmpf_pkg::CMD_CHECK;
  localparam logic [1:0]  CMD_ADD    = fmpf_pkg::CMD_ADD;
  localparam logic [1:0]  CMD_REMOVE = fmpf_pkg::CMD_REMOVE;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [1:0]  ACT_ALLOW  = fmpf_pkg::ACT_ALLOW;
  localparam logic [1:0]  ACT_LOG    = fmpf_pkg::ACT_LOG;
  localparam logic [1:0]  DIR_BOTH   = fmpf_pkg::DIR_BOTH;
  localparam logic [15:0] ID_MAX     = fmpf_pkg::ID_MAX;
  localparam logic [15:0] ID_FIRST   = fmpf_pkg::ID_FIRST;
  localparam logic [1:0] ACT_DENY = 2'd1;
  localparam logic [1:0] ACT_ODD  = 2'd3;
  localparam logic [1:0] DIR_IN   = 2'd0;
  localparam logic [1:0] DIR_OUT  = 2'd1;
  localparam logic [1:0] DIR_ODD  = 2'd3;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        filter_enable = 1'b0;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  logic [1:0]  cmd = '0;
  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [15:0] sport = '0;
  logic [15:0] dport = '0;
  logic [7:0]  proto = '0;
  logic [1:0]  dir = '0;
  logic [1:0]  action = '0;
  logic [15:0] rule_id = '0;
  wire         cfg_ready;
  wire         in_ready;
  wire         out_valid;
  wire         allow;
  wire  [1:0]  status;
  wire  [15:0] new_rule_id;
  wire  [fmpf_pkg::LOG_W-1:0] log_hits;

  int          fail_count;
  int          results_owed;
  logic [15:0] next_id_seen;

  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_request = 1'b0;
  int          hold_left = 0;
  bit          hold_done = 0;
  int          cycles = 0;

  first_match_packet_filter_core DUT (.*);
  fmpf_verdict_checker chk (.*);

  always #6 clk = ~clk;

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  function automatic fmpf_pkg::rule_t make_fields(logic [31:0] sip, logic [31:0] dip,
                                                  logic [15:0] sp, logic [15:0] dp,
                                                  logic [7:0] pr, logic [1:0] d,
                                                  logic [1:0] act, logic [15:0] id);
    return {sip, dip, sp, dp, pr, d, act, id};
  endfunction

  // Values from a small pool so that rules and packets meet often
  function automatic logic [31:0] pick_field(bit as_rule, logic [31:0] mask);
    logic [31:0] v;
    if (as_rule && $urandom_range(1)) return '0;
    case ($urandom_range(4))
      0:       v = 32'h0A00_0016;
      1:       v = 32'hC0A8_0050;
      2:       v = '1;
      3:       v = 32'h0000_0006;
      default: v = $urandom;
    endcase
    return v & mask;
  endfunction

  function automatic fmpf_pkg::rule_t random_fields(bit as_rule);
    fmpf_pkg::rule_t r;
    r.src_ip = pick_field(as_rule, '1);
    r.dst_ip = pick_field(as_rule, '1);
    r.sport  = 16'(pick_field(as_rule, 32'hFFFF));
    r.dport  = 16'(pick_field(as_rule, 32'hFFFF));
    r.proto  = 8'(pick_field(as_rule, 32'hFF));
    r.dir    = ($urandom_range(9) == 0) ? DIR_ODD : 2'($urandom_range(2));
    r.action = ($urandom_range(9) == 0) ? ACT_ODD : 2'($urandom_range(2));
    r.id     = 16'($urandom);
    return r;
  endfunction

  task automatic send_beat(input logic [1:0] c, input fmpf_pkg::rule_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    src_ip   <= r.src_ip;
    dst_ip   <= r.dst_ip;
    sport    <= r.sport;
    dport    <= r.dport;
    proto    <= r.proto;
    dir      <= r.dir;
    action   <= r.action;
    rule_id  <= r.id;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    cfg_valid     <= 1'b1;
    filter_enable <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: fill-heavy first, then rotate drain, mixed and fill mixes
  task automatic random_traffic(input int n, input int fill_len);
    logic [15:0]     id_guess;
    fmpf_pkg::rule_t r;
    logic [1:0]      c;
    int              i;
    int              mode;
    int              roll;
    int              add_pct;
    int              check_pct;
    int              remove_pct;
    id_guess = next_id_seen;
    for (i = 0; i < n; i++) begin
      mode = (i < fill_len) ? 0 : ((i / 40) + 1) % 3;
      case (mode)
        0:       begin add_pct = 55; check_pct = 35; remove_pct = 8;  end
        1:       begin add_pct = 10; check_pct = 40; remove_pct = 48; end
        default: begin add_pct = 30; check_pct = 45; remove_pct = 22; end
      endcase
      roll = $urandom_range(99);
      if (roll < add_pct) begin
        c = CMD_ADD;
        r = random_fields(1);
        id_guess = (id_guess == ID_MAX) ? ID_FIRST : id_guess + 16'd1;
      end else if (roll < add_pct + check_pct) begin
        c = CMD_CHECK;
        r = random_fields(0);
      end else if (roll < add_pct + check_pct + remove_pct) begin
        c = CMD_REMOVE;
        r = random_fields(0);
        roll = $urandom_range(99);
        if (roll < 5) r.id = '0;
        else if (roll < 75) r.id = id_guess - 16'($urandom_range(1, 70));
      end else begin
        c = CMD_UNUSED;
        r = random_fields(0);
      end
      send_beat(c, r);
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // filter disabled: everything passes
    send_beat(CMD_CHECK, make_fields('0, '0, '0, '0, '0, DIR_IN, ACT_ALLOW, '0));
    send_beat(CMD_UNUSED, make_fields('1, '1, '1, '1, '1, DIR_ODD, ACT_ODD, '1));
    send_beat(CMD_ADD, make_fields('0, '0, '0, '0, '0, DIR_BOTH, ACT_LOG, '0));
    send_beat(CMD_CHECK, make_fields('1, '1, 16'd22, 16'd22, 8'd6, DIR_OUT, ACT_ALLOW, '0));
    drain();
    write_enable(1'b1);

    send_beat(CMD_ADD, make_fields('1, '1, '1, '1, '1, DIR_IN, ACT_ALLOW, '1));
    send_beat(CMD_ADD, make_fields('0, '0, '0, 16'd22, 8'd6, DIR_OUT, ACT_DENY, '0));
    send_beat(CMD_ADD, make_fields(32'h0A00_0001, '0, '0, '0, '0, DIR_ODD, ACT_ODD, '0));
    send_beat(CMD_ADD, make_fields('0, '0, '0, '0, 8'd17, DIR_BOTH, ACT_LOG, '0));
    send_beat(CMD_ADD, make_fields('0, '0, '0, 16'd80, '0, DIR_BOTH, ACT_DENY, '0));
    send_beat(CMD_CHECK, make_fields('1, '1, '1, '1, '1, DIR_IN, ACT_ALLOW, '0));
    send_beat(CMD_CHECK, make_fields('1, '1, '1, '1, '1, DIR_OUT, ACT_ALLOW, '0));
    send_beat(CMD_CHECK,
              make_fields(32'h0102_0304, 32'h0506_0708, 16'd1024, 16'd22, 8'd6,
                          DIR_OUT, ACT_ALLOW, '0));
    send_beat(CMD_CHECK, make_fields(32'h0A00_0001, '1, 16'd5, 16'd7, 8'd1, DIR_ODD,
                                     ACT_ALLOW, '0));
    send_beat(CMD_CHECK, make_fields(32'h0A00_0001, '1, 16'd5, 16'd7, 8'd1, DIR_BOTH,
                                     ACT_ALLOW, '0));
    send_beat(CMD_CHECK, make_fields('1, 32'h0A00_0002, 16'd9, 16'd80, 8'd17, DIR_BOTH,
                                     ACT_ALLOW, '0));
    send_beat(CMD_REMOVE, make_fields('0, '0, '0, '0, '0, DIR_IN, ACT_ALLOW, 16'd0));
    send_beat(CMD_REMOVE, make_fields('0, '0, '0, '0, '0, DIR_IN, ACT_ALLOW, ID_MAX));
    send_beat(CMD_REMOVE, make_fields('0, '0, '0, '0, '0, DIR_IN, ACT_ALLOW, 16'd3));
    send_beat(CMD_CHECK,
              make_fields(32'h0102_0304, 32'h0506_0708, 16'd1024, 16'd22, 8'd6,
                          DIR_OUT, ACT_ALLOW, '0));
    send_beat(CMD_REMOVE, make_fields('0, '0, '0, '0, '0, DIR_IN, ACT_ALLOW, 16'd6));
    send_beat(CMD_REMOVE, make_fields('0, '0, '0, '0, '0, DIR_IN, ACT_ALLOW, 16'd2));
    send_beat(CMD_REMOVE, make_fields('0, '0, '0, '0, '0, DIR_IN, ACT_ALLOW, 16'd5));
    send_beat(CMD_REMOVE, make_fields('0, '0, '0, '0, '0, DIR_IN, ACT_ALLOW, 16'd4));
    send_beat(CMD_UNUSED, make_fields('1, '1, '1, '1, '1, DIR_ODD, ACT_ODD, '1));
    drain();

    // random traffic; the long receiver hold-off lands in the first mix
    hold_request <= 1'b1;
    random_traffic(150, 120);
    drain();
    idle_pct = 73;
    random_traffic(150, 0);
    drain();
    write_enable(1'b0);
    idle_pct  = 0;
    stall_pct = 73;
    random_traffic(100, 0);
    drain();
    write_enable(1'b1);
    idle_pct  = 23;
    stall_pct = 23;
    random_traffic(150, 0);
    drain();
    idle_pct  = 0;
    stall_pct = 73;
    random_traffic(150, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
